### src/bline_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bline_pkg;

  localparam int COORD_W       = 6;
  localparam int ERR_W         = COORD_W + 3;
  localparam int GRID_SIZE_DEF = 64;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic load;   // capture a new line request
    logic setup;  // derive deltas, axis and initial error
    logic step;   // current point taken, advance to the next one
  } bline_cmd_t;

  typedef struct packed {
    logic last;   // current point is the end point
  } bline_sts_t;

endpackage

`default_nettype wire

### src/bline_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bline_line_if;
  logic              valid;
  logic              ready;
  bline_pkg::coord_t start_x;
  bline_pkg::coord_t start_y;
  bline_pkg::coord_t end_x;
  bline_pkg::coord_t end_y;
  logic              pen_value;

  modport source (output valid, start_x, start_y, end_x, end_y, pen_value, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pen_value, output ready);
endinterface

interface bline_point_if;
  logic              valid;
  logic              ready;
  bline_pkg::coord_t point_x;
  bline_pkg::coord_t point_y;
  logic              point_value;
  logic              last_point;

  modport source (output valid, point_x, point_y, point_value, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_value, last_point, output ready);
endinterface

`default_nettype wire

### src/bresenham_line_points_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Payload                                       Request
// line_in    in   start_x, start_y, end_x, end_y, pen_value     one line
// point_out  out  point_x, point_y, point_value, last_point     one raster point
//
// A line goes through capture, then setup of the error term, then one point
// per cycle from the stepping datapath while point_out is ready (up to 64 points
// on a 64 grid). A new line is taken only after its last point has been taken.
// rst is synchronous; it returns the controller to idle and drops out valid.
// A stall on point_out holds the current point and the error term.

module bresenham_line_points_top #(
  parameter int GRID_SIZE = bline_pkg::GRID_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bline_line_if.sink    line_in,
  bline_point_if.source point_out
);
  import bline_pkg::*;

  bline_cmd_t cmd;
  bline_sts_t sts;

  bline_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line_in.valid),
    .in_ready  (line_in.ready),
    .out_valid (point_out.valid),
    .out_ready (point_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bline_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (line_in.start_x),
    .start_y     (line_in.start_y),
    .end_x       (line_in.end_x),
    .end_y       (line_in.end_y),
    .pen_value   (line_in.pen_value),
    .point_x     (point_out.point_x),
    .point_y     (point_out.point_y),
    .point_value (point_out.point_value),
    .last_point  (point_out.last_point)
  );

endmodule

`default_nettype wire

### src/bline_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bline_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  bline_pkg::bline_sts_t sts,
  output bline_pkg::bline_cmd_t cmd
);
  import bline_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);

  assign cmd.load  = (state == ST_IDLE) && in_valid;
  assign cmd.setup = (state == ST_SETUP);
  assign cmd.step  = (state == ST_EMIT) && out_ready;

endmodule

`default_nettype wire

### src/bline_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bline_dp #(
  parameter int GRID_SIZE = bline_pkg::GRID_SIZE_DEF
) (
  input  logic                  clk,
  input  bline_pkg::bline_cmd_t cmd,
  output bline_pkg::bline_sts_t sts,
  input  bline_pkg::coord_t     start_x,
  input  bline_pkg::coord_t     start_y,
  input  bline_pkg::coord_t     end_x,
  input  bline_pkg::coord_t     end_y,
  input  logic                  pen_value,
  output bline_pkg::coord_t     point_x,
  output bline_pkg::coord_t     point_y,
  output logic                  point_value,
  output logic                  last_point
);
  import bline_pkg::*;

  localparam coord_t COORD_MAX = COORD_W'(GRID_SIZE - 1);

  coord_t px;
  coord_t py;
  coord_t ex;
  coord_t ey;
  logic   pen;
  logic   x_down;
  logic   y_down;
  logic   horiz;
  coord_t major;
  coord_t minor;
  coord_t cnt;
  err_t   err;

  // setup-time values
  logic   x_down_c;
  logic   y_down_c;
  coord_t dx_c;
  coord_t dy_c;
  logic   horiz_c;
  coord_t major_c;
  coord_t minor_c;
  err_t   err_init;

  // step-time values
  err_t   minor2;
  err_t   major2;
  err_t   err_step;
  logic   err_pos;

  function automatic coord_t clamp(input coord_t c);
    clamp = (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  always_comb begin
    x_down_c = ex < px;
    y_down_c = ey < py;
    dx_c     = x_down_c ? (px - ex) : (ex - px);
    dy_c     = y_down_c ? (py - ey) : (ey - py);
    horiz_c  = dy_c <= dx_c;   // ties go horizontal
    major_c  = horiz_c ? dx_c : dy_c;
    minor_c  = horiz_c ? dy_c : dx_c;
    err_init = $signed({2'b00, minor_c, 1'b0}) - $signed({3'b000, major_c});
  end

  always_comb begin
    minor2   = $signed({2'b00, minor, 1'b0});
    major2   = $signed({2'b00, major, 1'b0});
    err_pos  = (err > 0);
    err_step = err_pos ? (err + minor2 - major2) : (err + minor2);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px  <= clamp(start_x);
      py  <= clamp(start_y);
      ex  <= clamp(end_x);
      ey  <= clamp(end_y);
      pen <= pen_value;
    end else if (cmd.setup) begin
      x_down <= x_down_c;
      y_down <= y_down_c;
      horiz  <= horiz_c;
      major  <= major_c;
      minor  <= minor_c;
      cnt    <= major_c;
      err    <= err_init;
    end else if (cmd.step) begin
      err <= err_step;
      cnt <= cnt - 1'b1;
      if (horiz || err_pos) px <= x_down ? (px - 1'b1) : (px + 1'b1);
      if (!horiz || err_pos) py <= y_down ? (py - 1'b1) : (py + 1'b1);
    end
  end

  assign sts.last    = (cnt == '0);
  assign point_x     = px;
  assign point_y     = py;
  assign point_value = pen;
  assign last_point  = (cnt == '0);

endmodule

`default_nettype wire

### verif/tb_bresenham_line_points_top.sv
`timescale 1ns / 1ps

module tb_bresenham_line_points_top;

  typedef bline_pkg::coord_t coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   value;
    logic   last;
  } raster_point_t;

  // Traces each accepted line into the points it should produce, then
  // matches the points leaving the block against them in order.
  class line_point_board;
    raster_point_t pending[$];
    int            mismatch_cnt;

    function new();
      mismatch_cnt = 0;
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_cnt++;
    endtask

    function void add_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, logic pen);
      int            x, y, dx, dy, x_step, y_step, major, minor, err;
      bit            horiz;
      raster_point_t p;
      x      = sx;
      y      = sy;
      x_step = (ex < sx) ? -1 : 1;
      y_step = (ey < sy) ? -1 : 1;
      dx     = (ex < sx) ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
      dy     = (ey < sy) ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
      horiz  = (dy <= dx);  // ties go horizontal
      major  = horiz ? dx : dy;
      minor  = horiz ? dy : dx;
      err    = 2 * minor - major;
      for (int i = 0; i <= major; i++) begin
        p.x     = coord_t'(x);
        p.y     = coord_t'(y);
        p.value = pen;
        p.last  = (i == major);
        pending.push_back(p);
        if (err > 0) begin
          if (horiz) y += y_step;
          else       x += x_step;
          err -= 2 * major;
        end
        err += 2 * minor;
        if (horiz) x += x_step;
        else       y += y_step;
      end
    endfunction

    task check_point(raster_point_t got);
      raster_point_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d,%0d)", got.x, got.y));
      end else begin
        want = pending.pop_front();
        if (got.x !== want.x)
          report_mismatch($sformatf("point_x %0d, want %0d", got.x, want.x));
        if (got.y !== want.y)
          report_mismatch($sformatf("point_y %0d, want %0d", got.y, want.y));
        if (got.value !== want.value)
          report_mismatch($sformatf("point_value %b, want %b", got.value, want.value));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_point %b, want %b at (%0d,%0d)",
                                    got.last, want.last, want.x, want.y));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bline_line_if  line_ch ();
  bline_point_if point_ch ();

  bresenham_line_points_top dut (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_ch),
    .point_out (point_ch)
  );

  always #1 clk = ~clk;

  line_point_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always @(posedge clk) begin
    if (rst) begin
      point_ch.ready <= 1'b0;
    end else begin
      if (point_ch.valid && point_ch.ready)
        board.check_point({point_ch.point_x, point_ch.point_y,
                           point_ch.point_value, point_ch.last_point});
      point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, logic pen);
    while ($urandom_range(99) < send_idle_pct) begin
      line_ch.valid <= 1'b0;
      @(posedge clk);
    end
    line_ch.valid     <= 1'b1;
    line_ch.start_x   <= sx;
    line_ch.start_y   <= sy;
    line_ch.end_x     <= ex;
    line_ch.end_y     <= ey;
    line_ch.pen_value <= pen;
    do @(posedge clk); while (!line_ch.ready);
    board.add_line(sx, sy, ex, ey, pen);
  endtask

  task drain_points();
    line_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function coord_t near_coord(coord_t base);
    int c;
    c = int'(base) + $urandom_range(8) - 4;
    if (c < 0)  c = 0;
    if (c > 63) c = 63;
    return coord_t'(c);
  endfunction

  task send_random_line();
    coord_t sx, sy, ex, ey;
    int     kind;
    kind = $urandom_range(9);
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    ex = coord_t'($urandom);
    ey = coord_t'($urandom);
    if (kind >= 6 && kind <= 8) begin
      // short lines keep the point count down and hit the ends often
      ex = near_coord(sx);
      ey = near_coord(sy);
    end else if (kind == 9) begin
      sx = $urandom_range(1) ? 6'd63 : 6'd0;
      sy = $urandom_range(1) ? 6'd63 : 6'd0;
      ex = $urandom_range(1) ? 6'd63 : 6'd0;
      ey = $urandom_range(1) ? 6'd63 : 6'd0;
    end
    send_line(sx, sy, ex, ey, 1'($urandom));
  endtask

  initial begin
    line_ch.valid     = 1'b0;
    line_ch.start_x   = '0;
    line_ch.start_y   = '0;
    line_ch.end_x     = '0;
    line_ch.end_y     = '0;
    line_ch.pen_value = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single points, full-length axes and diagonals, all eight octants
    send_line(6'd0,  6'd0,  6'd0,  6'd0,  1'b0);
    send_line(6'd63, 6'd63, 6'd63, 6'd63, 1'b1);
    send_line(6'd0,  6'd0,  6'd63, 6'd0,  1'b1);
    send_line(6'd63, 6'd0,  6'd0,  6'd0,  1'b0);
    send_line(6'd0,  6'd0,  6'd0,  6'd63, 1'b1);
    send_line(6'd0,  6'd63, 6'd0,  6'd0,  1'b0);
    send_line(6'd0,  6'd0,  6'd63, 6'd63, 1'b1);
    send_line(6'd63, 6'd63, 6'd0,  6'd0,  1'b0);
    send_line(6'd63, 6'd0,  6'd0,  6'd63, 1'b1);
    send_line(6'd0,  6'd63, 6'd63, 6'd0,  1'b0);
    send_line(6'd10, 6'd20, 6'd40, 6'd31, 1'b1);
    send_line(6'd40, 6'd31, 6'd10, 6'd20, 1'b0);
    send_line(6'd10, 6'd31, 6'd40, 6'd20, 1'b1);
    send_line(6'd40, 6'd20, 6'd10, 6'd31, 1'b0);
    send_line(6'd20, 6'd10, 6'd31, 6'd40, 1'b1);
    send_line(6'd31, 6'd40, 6'd20, 6'd10, 1'b0);
    send_line(6'd31, 6'd10, 6'd20, 6'd40, 1'b1);
    send_line(6'd20, 6'd40, 6'd31, 6'd10, 1'b0);
    send_line(6'd5,  6'd5,  6'd8,  6'd8,  1'b1);
    send_line(6'd7,  6'd3,  6'd3,  6'd7,  1'b0);
    send_line(6'd42, 6'd21, 6'd21, 6'd42, 1'b1);
    send_line(6'd0,  6'd0,  6'd1,  6'd0,  1'b1);
    send_line(6'd1,  6'd1,  6'd0,  6'd2,  1'b0);
    drain_points();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (37) send_random_line();
      drain_points();
    end

    repeat (10) @(posedge clk);
    if (board.pending.size() != 0)
      board.report_mismatch($sformatf("%0d points never came", board.pending.size()));
    if (board.mismatch_cnt == 0) begin
      $display("tb_bresenham_line_points_top OK");
    end else begin
      $display("tb_bresenham_line_points_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_bresenham_line_points_top NOT OK");
    $finish;
  end

endmodule
